// ----- rtl/core/tcgr_pkg.sv -----
// Shared types and constants for the text console glyph renderer.
package tcgr_pkg;

	// Default glyph geometry and tab expansion
	localparam int GLYPH_HEIGHT_DEF = 8;
	localparam int GLYPH_WIDTH_DEF  = 8;
	localparam int TAB_SPACES_DEF   = 8;

	// Queue depths (powers of two)
	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 4;

	// Input modes
	localparam logic [1:0] MODE_PUT  = 2'd0;
	localparam logic [1:0] MODE_SET  = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	// Control characters
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Configuration register indexes
	localparam logic [2:0] REG_FG_RED   = 3'd0;
	localparam logic [2:0] REG_FG_GREEN = 3'd1;
	localparam logic [2:0] REG_FG_BLUE  = 3'd2;
	localparam logic [2:0] REG_BG_RED   = 3'd3;
	localparam logic [2:0] REG_BG_GREEN = 3'd4;
	localparam logic [2:0] REG_BG_BLUE  = 3'd5;
	localparam logic [2:0] REG_HEIGHT   = 3'd6;

	// Packed RGB565 colors handed from front to back
	typedef struct packed {
		logic [15:0] fg;
		logic [15:0] bg;
	} colors_t;

	// Command carried from front to back
	typedef struct packed {
		logic        is_load;
		logic        is_tab;
		logic [7:0]  code;
		logic [2:0]  row;
		logic [7:0]  bits;
		logic [15:0] col;
		logic [11:0] line;
		logic [15:0] end_col;
		logic [11:0] end_line;
	} cmd_t;

	// Glyph row waiting for the consumer, pixels still as font bits
	typedef struct packed {
		logic [7:0]  bits;
		logic [15:0] x;
		logic [12:0] y;
		logic [15:0] cx;
		logic [11:0] cy;
		logic        last;
	} row_t;

endpackage

// ----- rtl/core/text_console_glyph_renderer.sv -----
// Top level of the text console glyph renderer.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------------
//  input     push / full          mode, char_code, font_row, row_bits, new_x, new_y
//  result    pop / empty          pixel_x, pixel_y, pixels_left, pixels_right,
//                                 cursor_x, cursor_y, last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A character yields GLYPH_HEIGHT results, a tab GLYPH_HEIGHT * TAB_SPACES, one per
// cycle while the result queue has room, paced by the single read port of the font
// memory; a new character follows with no gap. Reset zeroes the cursor, restores
// the color and height registers and empties the queues; the font memory is not
// cleared and must be loaded before use. Input stalls while the two-entry command
// queue is full; the back end stalls while the result queue has no free entry.
module text_console_glyph_renderer #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
	parameter int GLYPH_WIDTH  = tcgr_pkg::GLYPH_WIDTH_DEF,
	parameter int TAB_SPACES   = tcgr_pkg::TAB_SPACES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  char_code,
	input  logic [2:0]  font_row,
	input  logic [7:0]  row_bits,
	input  logic [15:0] new_x,
	input  logic [11:0] new_y,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] pixel_x,
	output logic [12:0] pixel_y,
	output logic [63:0] pixels_left,
	output logic [63:0] pixels_right,
	output logic [15:0] cursor_x,
	output logic [11:0] cursor_y,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int QCW = $clog2(tcgr_pkg::CMDQ_DEPTH + 1);

	logic              cmd_wr;
	tcgr_pkg::cmd_t    cmd;
	tcgr_pkg::cmd_t    cmdq_data;
	logic              cmdq_empty;
	logic              cmdq_rd;
	logic [QCW-1:0]    cmdq_count;
	tcgr_pkg::colors_t colors;

	// Registers accept every transfer
	assign cfg_ready = 1'b1;

	tcgr_front #(
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.TAB_SPACES   (TAB_SPACES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.mode      (mode),
		.char_code (char_code),
		.font_row  (font_row),
		.row_bits  (row_bits),
		.new_x     (new_x),
		.new_y     (new_y),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmdq_full (full),
		.cmd_wr    (cmd_wr),
		.cmd       (cmd),
		.colors    (colors)
	);

	// Command queue between front and back
	tcgr_fifo #(
		.WIDTH ($bits(tcgr_pkg::cmd_t)),
		.DEPTH (tcgr_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd),
		.full    (full),
		.rd_en   (cmdq_rd),
		.rd_data (cmdq_data),
		.empty   (cmdq_empty),
		.count   (cmdq_count)
	);

	tcgr_back #(
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.TAB_SPACES   (TAB_SPACES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmdq_empty   (cmdq_empty),
		.cmdq_data    (cmdq_data),
		.cmdq_rd      (cmdq_rd),
		.colors       (colors),
		.pop          (pop),
		.empty        (empty),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixels_left  (pixels_left),
		.pixels_right (pixels_right),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.last         (last)
	);

endmodule

// ----- rtl/core/tcgr_fifo.sv -----
// Small first-in first-out queue with occupancy count (depth a power of two).
module tcgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	output logic                         full,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/tcgr_front.sv -----
// Front end: configuration registers, cursor tracking and command classification.
module tcgr_front #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
	parameter int GLYPH_WIDTH  = tcgr_pkg::GLYPH_WIDTH_DEF,
	parameter int TAB_SPACES   = tcgr_pkg::TAB_SPACES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [1:0]         mode,
	input  logic [7:0]         char_code,
	input  logic [2:0]         font_row,
	input  logic [7:0]         row_bits,
	input  logic [15:0]        new_x,
	input  logic [11:0]        new_y,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic               cmdq_full,
	output logic               cmd_wr,
	output tcgr_pkg::cmd_t     cmd,
	output tcgr_pkg::colors_t  colors
);

	logic [4:0]  fg_red_q;
	logic [5:0]  fg_green_q;
	logic [4:0]  fg_blue_q;
	logic [4:0]  bg_red_q;
	logic [5:0]  bg_green_q;
	logic [4:0]  bg_blue_q;
	logic [11:0] height_q;
	logic [15:0] col_q;
	logic [11:0] line_q;

	logic        accept;
	logic [11:0] line_c;
	logic [11:0] line_lf;
	logic [15:0] col_n;
	logic [11:0] line_n;
	logic [16:0] col_one;
	logic [16:0] col_tab;

	// Pull the line up so a whole glyph fits above the screen bottom
	function automatic logic [11:0] clamp_line(input logic [12:0] l, input logic [11:0] h);
		logic [13:0] sum;
		logic [11:0] res;
		sum = {1'b0, l} + 14'(GLYPH_HEIGHT);
		if ({2'b00, h} <= sum) begin
			res = (h >= 12'(GLYPH_HEIGHT)) ? h - 12'(GLYPH_HEIGHT) : 12'd0;
		end else begin
			res = l[11:0];
		end
		return res;
	endfunction

	assign accept = push && !cmdq_full;
	assign colors.fg = {fg_red_q, fg_green_q, fg_blue_q};
	assign colors.bg = {bg_red_q, bg_green_q, bg_blue_q};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_red_q   <= 5'd0;
			fg_green_q <= 6'd0;
			fg_blue_q  <= 5'd31;
			bg_red_q   <= 5'd31;
			bg_green_q <= 6'd63;
			bg_blue_q  <= 5'd31;
			height_q   <= 12'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				tcgr_pkg::REG_FG_RED:   fg_red_q   <= cfg_data[4:0];
				tcgr_pkg::REG_FG_GREEN: fg_green_q <= cfg_data[5:0];
				tcgr_pkg::REG_FG_BLUE:  fg_blue_q  <= cfg_data[4:0];
				tcgr_pkg::REG_BG_RED:   bg_red_q   <= cfg_data[4:0];
				tcgr_pkg::REG_BG_GREEN: bg_green_q <= cfg_data[5:0];
				tcgr_pkg::REG_BG_BLUE:  bg_blue_q  <= cfg_data[4:0];
				tcgr_pkg::REG_HEIGHT:   height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Work out where the cursor lands after this character
	always_comb begin
		line_c  = clamp_line({1'b0, line_q}, height_q);
		line_lf = clamp_line({1'b0, line_c} + 13'(GLYPH_HEIGHT), height_q);
		col_one = {1'b0, col_q} + 17'(GLYPH_WIDTH);
		col_tab = {1'b0, col_q} + 17'(GLYPH_WIDTH * TAB_SPACES);
		line_n  = line_c;
		case (char_code)
			tcgr_pkg::CHAR_LF: begin
				col_n  = 16'd0;
				line_n = line_lf;
			end
			tcgr_pkg::CHAR_CR: begin
				col_n = 16'd0;
			end
			tcgr_pkg::CHAR_TAB: begin
				col_n = col_tab[16] ? 16'hffff : col_tab[15:0];
			end
			default: begin
				col_n = col_one[16] ? 16'hffff : col_one[15:0];
			end
		endcase
	end

	// Build the command for the back end; only a drawn tab becomes spaces
	always_comb begin
		cmd.is_load  = (mode == tcgr_pkg::MODE_LOAD);
		cmd.is_tab   = (char_code == tcgr_pkg::CHAR_TAB);
		cmd.code     = (mode == tcgr_pkg::MODE_PUT && char_code == tcgr_pkg::CHAR_TAB) ?
			tcgr_pkg::CHAR_SPACE : char_code;
		cmd.row      = font_row;
		cmd.bits     = row_bits;
		cmd.col      = col_q;
		cmd.line     = line_c;
		cmd.end_col  = col_n;
		cmd.end_line = line_n;
		cmd_wr       = accept && (mode == tcgr_pkg::MODE_PUT || mode == tcgr_pkg::MODE_LOAD);
	end

	// Track the cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= 16'd0;
			line_q <= 12'd0;
		end else if (accept) begin
			if (mode == tcgr_pkg::MODE_SET) begin
				col_q  <= new_x;
				line_q <= new_y;
			end else if (mode == tcgr_pkg::MODE_PUT) begin
				col_q  <= col_n;
				line_q <= line_n;
			end
		end
	end

endmodule

// ----- rtl/core/tcgr_back.sv -----
// Back end: font memory, glyph row sequencer, result queue and pixel expansion.
module tcgr_back #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
	parameter int GLYPH_WIDTH  = tcgr_pkg::GLYPH_WIDTH_DEF,
	parameter int TAB_SPACES   = tcgr_pkg::TAB_SPACES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmdq_empty,
	input  tcgr_pkg::cmd_t     cmdq_data,
	output logic               cmdq_rd,
	input  tcgr_pkg::colors_t  colors,
	input  logic               pop,
	output logic               empty,
	output logic [15:0]        pixel_x,
	output logic [12:0]        pixel_y,
	output logic [63:0]        pixels_left,
	output logic [63:0]        pixels_right,
	output logic [15:0]        cursor_x,
	output logic [11:0]        cursor_y,
	output logic               last
);

	localparam int CW = $clog2(tcgr_pkg::OUTQ_DEPTH + 1);

	logic [7:0]  font_mem [2048];

	logic        busy_q;
	logic [7:0]  code_q;
	logic        tab_q;
	logic [15:0] col_q;
	logic [11:0] line_q;
	logic [15:0] end_col_q;
	logic [11:0] end_line_q;
	logic [2:0]  row_q;
	logic [2:0]  glyph_q;

	logic        vld_s1;
	logic [7:0]  bits_s1;
	logic [15:0] x_s1;
	logic [12:0] y_s1;
	logic [15:0] cx_s1;
	logic [11:0] cy_s1;
	logic        last_s1;

	logic        issue;
	logic        row_end;
	logic        glyph_end;
	logic        fin;
	logic        take;
	logic        font_we;
	logic [16:0] col_adv;
	logic [CW:0] in_use;
	logic [CW-1:0] outq_count;
	logic        outq_full;
	tcgr_pkg::row_t outq_wdata;
	tcgr_pkg::row_t outq_rdata;

	// Sequencer control
	assign in_use    = {1'b0, outq_count} + (CW+1)'(vld_s1);
	assign issue     = busy_q && (in_use < (CW+1)'(tcgr_pkg::OUTQ_DEPTH));
	assign row_end   = (row_q == 3'(GLYPH_HEIGHT - 1));
	assign glyph_end = !tab_q || (glyph_q == 3'(TAB_SPACES - 1));
	assign fin       = issue && row_end && glyph_end;
	assign take      = !cmdq_empty && (!busy_q || fin);
	assign cmdq_rd   = take;
	assign font_we   = take && cmdq_data.is_load;
	assign col_adv   = {1'b0, col_q} + 17'(GLYPH_WIDTH);

	// Font store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[{cmdq_data.code, cmdq_data.row}] <= cmdq_data.bits;
		end
		if (issue) begin
			bits_s1 <= font_mem[{code_q, row_q}];
		end
	end

	// Hold the command being drawn, advance row and glyph
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			row_q   <= 3'd0;
			glyph_q <= 3'd0;
		end else begin
			if (issue) begin
				if (row_end) begin
					row_q   <= 3'd0;
					glyph_q <= glyph_q + 3'd1;
				end else begin
					row_q <= row_q + 3'd1;
				end
			end
			if (fin) begin
				busy_q <= 1'b0;
			end
			if (take && !cmdq_data.is_load) begin
				busy_q  <= 1'b1;
				row_q   <= 3'd0;
				glyph_q <= 3'd0;
			end
		end
	end

	// Command payload
	always_ff @(posedge clk) begin
		if (take && !cmdq_data.is_load) begin
			code_q     <= cmdq_data.code;
			tab_q      <= cmdq_data.is_tab;
			col_q      <= cmdq_data.col;
			line_q     <= cmdq_data.line;
			end_col_q  <= cmdq_data.end_col;
			end_line_q <= cmdq_data.end_line;
		end else if (issue && row_end) begin
			col_q <= col_adv[16] ? 16'hffff : col_adv[15:0];
		end
	end

	// Stage 1: row position alongside the font read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1    <= col_q;
			y_s1    <= {1'b0, line_q} + 13'(row_q);
			cx_s1   <= end_col_q;
			cy_s1   <= end_line_q;
			last_s1 <= row_end && glyph_end;
		end
	end

	always_comb begin
		outq_wdata.bits = bits_s1;
		outq_wdata.x    = x_s1;
		outq_wdata.y    = y_s1;
		outq_wdata.cx   = cx_s1;
		outq_wdata.cy   = cy_s1;
		outq_wdata.last = last_s1;
	end

	// Result queue; credit check above keeps it from overflowing
	tcgr_fifo #(
		.WIDTH ($bits(tcgr_pkg::row_t)),
		.DEPTH (tcgr_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (vld_s1),
		.wr_data (outq_wdata),
		.full    (outq_full),
		.rd_en   (pop),
		.rd_data (outq_rdata),
		.empty   (empty),
		.count   (outq_count)
	);

	// Expand font bits to RGB565 on the way out
	always_comb begin
		pixels_left  = 64'd0;
		pixels_right = 64'd0;
		for (int j = 0; j < 4; j++) begin
			if (j < GLYPH_WIDTH) begin
				pixels_left[16*j +: 16] = outq_rdata.bits[j] ? colors.fg : colors.bg;
			end
			if (j + 4 < GLYPH_WIDTH) begin
				pixels_right[16*j +: 16] = outq_rdata.bits[j+4] ? colors.fg : colors.bg;
			end
		end
		pixel_x  = outq_rdata.x;
		pixel_y  = outq_rdata.y;
		cursor_x = outq_rdata.cx;
		cursor_y = outq_rdata.cy;
		last     = outq_rdata.last && !outq_full | outq_rdata.last;
	end

endmodule
